// ===== rtl/core/plti_pkg.sv =====
// Shared widths, constants and the power-up breakpoint curve for the table interpolator.
`default_nettype none

package plti_pkg;

  // Field widths
  localparam int IDX_W   = 5;
  localparam int X_W     = 8;
  localparam int Y_W     = 16;
  localparam int CNT_W   = 6;
  localparam int SPAN_W  = 8;
  localparam int PROD_W  = 24;   // |dy| * dx magnitude, also covers the Celsius numerator
  localparam int CEL_W   = 20;   // 10*f - 308 as a signed value
  localparam int PT_W    = X_W + Y_W;

  // Stream packing
  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  // Table defaults
  localparam int DEFAULT_MAX_POINTS = 32;
  localparam int DFLT_POINTS        = 22;
  localparam int DFLT_COUNT         = 22;

  // Conversion constants
  localparam int NO_MATCH_VALUE = -125;
  localparam int CEL_OFFSET     = 308;
  localparam int CEL_DIV        = 18;

  // Input item kinds carried on tuser
  typedef enum logic {
    FUNC_WRITE   = 1'b0,
    FUNC_CONVERT = 1'b1
  } func_t;

  localparam logic [X_W-1:0] DFLT_X [DFLT_POINTS] = '{
    8'd0,   8'd5,   8'd10,  8'd20,  8'd30,  8'd40,  8'd50,  8'd70,  8'd80,  8'd90,  8'd100,
    8'd130, 8'd150, 8'd152, 8'd154, 8'd158, 8'd160, 8'd176, 8'd180, 8'd184, 8'd185, 8'd255
  };

  localparam logic [Y_W-1:0] DFLT_Y [DFLT_POINTS] = '{
    -16'sd49, -16'sd45, -16'sd42, -16'sd22, -16'sd7, 16'sd5, 16'sd16, 16'sd34,
    16'sd42,  16'sd49,  16'sd57,  16'sd78,  16'sd94, 16'sd96, 16'sd97, 16'sd101,
    16'sd102, 16'sd118, 16'sd121, 16'sd126, 16'sd127, 16'sd127
  };

  // Power-up point for a slot, packed {y, x}; slots past the curve read as zero
  function automatic logic [PT_W-1:0] dflt_point(input logic [7:0] idx);
    logic [PT_W-1:0] pt;
    pt = '0;
    if (idx < 8'(DFLT_POINTS)) begin
      pt = {DFLT_Y[idx[IDX_W-1:0]], DFLT_X[idx[IDX_W-1:0]]};
    end
    return pt;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/core/piecewise_linear_table_interp_unit.sv =====
// Piecewise-linear table interpolator with Fahrenheit-to-Celsius output.
//
// Input stream (s_axis_*): tuser = 0 writes one breakpoint into the slot in
// point_index (slots at or past MAX_POINTS are dropped), tuser = 1 converts
// the sample byte. A write gives no result. A convert gives one result on
// m_axis_*: interpolated value, Celsius value and the in-range flag on
// tuser. A convert with two or more points in use walks the segments in
// order until one holds the sample; a zero-width segment skips the
// multiply and the first divide. A sample in no segment, or fewer than two
// points in use, gives a miss. The segment walk reads one table entry per
// cycle from the single RAM read port; the multiply runs one multiplier bit
// per cycle and both divides run one quotient bit per cycle through one
// shared divider. One convert is in flight at a time.
// The next item is taken as soon as the result sits in the output register,
// so a stalled receiver only blocks once a second result is ready.
// cfg_we writes point_count; do so only while idle.
// Reset restores the 22-point default curve and point_count = 22 and
// empties the output register.
`default_nettype none

module piecewise_linear_table_interp_unit
  import plti_pkg::*;
#(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CNT_W-1:0]      cfg_wdata,     // point_count
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [IN_DATA_W-1:0]  s_axis_tdata,  // point_index[4:0], point_x[12:5],
                                                    // point_y[28:13], sample[36:29]
  input  wire logic                  s_axis_tuser,  // func
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [OUT_DATA_W-1:0]      m_axis_tdata,  // fahrenheit[15:0], celsius[31:16]
  output logic                       m_axis_tuser   // in_range
);

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int NW = (CW > CNT_W) ? CW : CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIRST,
    ST_WALK,
    ST_MUL,
    ST_DIVF_GO,
    ST_DIVF_WAIT,
    ST_CEL_GO,
    ST_CEL_WAIT,
    ST_RESULT
  } state_t;

  state_t state;

  // Input fields
  logic              in_func;
  logic [IDX_W-1:0]  in_index;
  logic [X_W-1:0]    in_x;
  logic [Y_W-1:0]    in_y;
  logic [X_W-1:0]    in_sample;
  logic              in_xfer;
  logic              idx_ok;

  assign in_func   = s_axis_tuser;
  assign in_index  = s_axis_tdata[4:0];
  assign in_x      = s_axis_tdata[12:5];
  assign in_y      = s_axis_tdata[28:13];
  assign in_sample = s_axis_tdata[36:29];

  assign s_axis_tready = (state == ST_IDLE);
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign idx_ok        = ({27'd0, in_index} < MAX_POINTS);

  // Registers
  logic [CNT_W-1:0]  point_count;
  logic [AW-1:0]     idx;
  logic [X_W-1:0]    samp;
  logic [X_W-1:0]    prev_x;
  logic [Y_W-1:0]    prev_y;
  logic [SPAN_W-1:0] span_r;
  logic              dneg;
  logic [PROD_W-1:0] mcand;
  logic [X_W-1:0]    mplier;
  logic [PROD_W-1:0] acc;
  logic [2:0]        mstep;
  logic [Y_W-1:0]    fval;
  logic              hit;
  logic              cneg;

  // Table
  logic [AW-1:0]     rd_addr;
  logic [X_W-1:0]    cur_x;
  logic [Y_W-1:0]    cur_y;

  plti_table #(
    .MAX_POINTS (MAX_POINTS)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .we    (in_xfer && in_func == FUNC_WRITE && idx_ok),
    .waddr (AW'(in_index)),
    .wx    (in_x),
    .wy    (in_y),
    .raddr (rd_addr),
    .rx    (cur_x),
    .ry    (cur_y)
  );

  // Read address runs one entry ahead of the compare
  always_comb begin
    case (state)
      ST_IDLE:  rd_addr = '0;
      ST_FIRST: rd_addr = AW'(1);
      ST_WALK:  rd_addr = idx + 1'b1;
      default:  rd_addr = '0;
    endcase
  end

  // Points in use, capped at the table size
  logic [NW-1:0] cnt_ext;
  logic [NW-1:0] n_eff;
  logic [NW-1:0] idx_p1;
  logic          n_small;
  logic          last_seg;

  assign cnt_ext  = NW'(point_count);
  assign n_eff    = (cnt_ext > NW'(MAX_POINTS)) ? NW'(MAX_POINTS) : cnt_ext;
  assign n_small  = (n_eff < NW'(2));
  assign idx_p1   = NW'(idx) + NW'(1);
  assign last_seg = (idx_p1 == n_eff);

  // Segment test and operands
  logic              seg_hit;
  logic [Y_W:0]      dy;
  logic [Y_W:0]      dmag;
  logic [X_W-1:0]    dx;
  logic [SPAN_W-1:0] span;

  assign seg_hit = (prev_x <= samp) && (cur_x >= samp);
  assign dy      = {cur_y[Y_W-1], cur_y} - {prev_y[Y_W-1], prev_y};
  assign dmag    = dy[Y_W] ? -dy : dy;
  assign dx      = samp - prev_x;
  assign span    = cur_x - prev_x;

  // Divider
  logic              div_start;
  logic [PROD_W-1:0] div_dividend;
  logic [SPAN_W-1:0] div_divisor;
  logic [PROD_W-1:0] div_q;
  logic              div_done;

  // Celsius numerator 10*f - 308
  logic [CEL_W-1:0]  fe;
  logic [CEL_W-1:0]  cnum;
  logic [CEL_W-1:0]  cmag;

  assign fe   = {{(CEL_W - Y_W){fval[Y_W-1]}}, fval};
  assign cnum = (fe << 3) + (fe << 1) - CEL_W'(CEL_OFFSET);
  assign cmag = cnum[CEL_W-1] ? -cnum : cnum;

  assign div_start    = (state == ST_DIVF_GO) || (state == ST_CEL_GO);
  assign div_dividend = (state == ST_CEL_GO) ? PROD_W'(cmag) : acc;
  assign div_divisor  = (state == ST_CEL_GO) ? SPAN_W'(CEL_DIV) : span_r;

  plti_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .quotient (div_q),
    .done     (div_done)
  );

  // Signed results from the quotient magnitude
  logic [Y_W:0]   qs;
  logic [Y_W:0]   val;
  logic [Y_W-1:0] cel;

  assign qs  = dneg ? -{1'b0, div_q[Y_W-1:0]} : {1'b0, div_q[Y_W-1:0]};
  assign val = {prev_y[Y_W-1], prev_y} + qs;
  assign cel = cneg ? -div_q[Y_W-1:0] : div_q[Y_W-1:0];

  // Finished result moves into the output register once it is free
  logic out_load;

  assign out_load = (state == ST_RESULT) && (!m_axis_tvalid || m_axis_tready);

  // Control and datapath registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      point_count   <= CNT_W'(DFLT_COUNT);
      m_axis_tvalid <= 1'b0;
    end else begin
      if (cfg_we) begin
        point_count <= cfg_wdata;
      end

      // Output register: load a finished result, else empty on transfer
      if (out_load) begin
        m_axis_tdata  <= {cel, fval};
        m_axis_tuser  <= hit;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tvalid && m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end

      case (state)
        ST_IDLE: begin
          if (in_xfer && in_func == FUNC_CONVERT) begin
            samp <= in_sample;
            if (n_small) begin
              fval  <= Y_W'(NO_MATCH_VALUE);
              hit   <= 1'b0;
              state <= ST_CEL_GO;
            end else begin
              state <= ST_FIRST;
            end
          end
        end

        ST_FIRST: begin
          prev_x <= cur_x;
          prev_y <= cur_y;
          idx    <= AW'(1);
          state  <= ST_WALK;
        end

        // One segment per cycle; stop at the first that holds the sample
        ST_WALK: begin
          if (seg_hit) begin
            hit <= 1'b1;
            if (span == '0) begin
              fval  <= prev_y;
              state <= ST_CEL_GO;
            end else begin
              span_r <= span;
              dneg   <= dy[Y_W];
              mcand  <= PROD_W'(dmag);
              mplier <= dx;
              acc    <= '0;
              mstep  <= '0;
              state  <= ST_MUL;
            end
          end else if (last_seg) begin
            fval  <= Y_W'(NO_MATCH_VALUE);
            hit   <= 1'b0;
            state <= ST_CEL_GO;
          end else begin
            prev_x <= cur_x;
            prev_y <= cur_y;
            idx    <= idx + 1'b1;
          end
        end

        // Shift-add multiply, one multiplier bit per cycle
        ST_MUL: begin
          if (mplier[0]) begin
            acc <= acc + mcand;
          end
          mcand  <= mcand << 1;
          mplier <= mplier >> 1;
          mstep  <= mstep + 1'b1;
          if (mstep == 3'd7) begin
            state <= ST_DIVF_GO;
          end
        end

        ST_DIVF_GO: begin
          state <= ST_DIVF_WAIT;
        end

        ST_DIVF_WAIT: begin
          if (div_done) begin
            fval  <= val[Y_W-1:0];
            state <= ST_CEL_GO;
          end
        end

        ST_CEL_GO: begin
          cneg  <= cnum[CEL_W-1];
          state <= ST_CEL_WAIT;
        end

        ST_CEL_WAIT: begin
          if (div_done) begin
            state <= ST_RESULT;
          end
        end

        // Wait here until the output register takes the result
        ST_RESULT: begin
          if (out_load) begin
            state <= ST_IDLE;
          end
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/plti_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module plti_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/core/plti_table.sv =====
// Breakpoint table: RAM plus per-slot written flags, unwritten slots read the power-up curve.
`default_nettype none

module plti_table
  import plti_pkg::*;
#(
  parameter int MAX_POINTS = DEFAULT_MAX_POINTS
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          we,
  input  wire logic [$clog2(MAX_POINTS)-1:0] waddr,
  input  wire logic [X_W-1:0]                wx,
  input  wire logic [Y_W-1:0]                wy,
  input  wire logic [$clog2(MAX_POINTS)-1:0] raddr,
  output logic      [X_W-1:0]                rx,
  output logic      [Y_W-1:0]                ry
);

  logic [MAX_POINTS-1:0] written;
  logic                  rd_written;
  logic [PT_W-1:0]       rd_dflt;
  logic [PT_W-1:0]       ram_q;
  logic [PT_W-1:0]       rd_pt;

  plti_ram #(
    .WIDTH (PT_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata ({wy, wx}),
    .raddr (raddr),
    .rdata (ram_q)
  );

  // Written flags, cleared at reset so the table starts on the default curve
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // Flag and default are registered alongside the RAM read so they line up with its data
  always_ff @(posedge clk) begin
    rd_written <= written[raddr];
    rd_dflt    <= dflt_point(8'(raddr));
  end

  assign rd_pt = rd_written ? ram_q : rd_dflt;
  assign rx    = rd_pt[X_W-1:0];
  assign ry    = rd_pt[PT_W-1:X_W];

endmodule

`default_nettype wire

// ===== rtl/core/plti_serial_div.sv =====
// Restoring divider, one quotient bit per cycle, shared by both divides.
`default_nettype none

module plti_serial_div
  import plti_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              start,
  input  wire logic [PROD_W-1:0] dividend,
  input  wire logic [SPAN_W-1:0] divisor,
  output logic      [PROD_W-1:0] quotient,
  output logic                   done
);

  localparam int SW = $clog2(PROD_W);

  logic              busy;
  logic [SW-1:0]     step;
  logic [SPAN_W-1:0] rem;
  logic [SPAN_W-1:0] dvs;
  logic [SPAN_W:0]   rem_sh;
  logic              ge;

  // Bring down the next dividend bit and try the subtract
  assign rem_sh = {rem, quotient[PROD_W-1]};
  assign ge     = (rem_sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !start && busy && (step == SW'(PROD_W - 1));
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == SW'(PROD_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

  // Datapath: quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      dvs      <= divisor;
      step     <= '0;
    end else if (busy) begin
      rem      <= ge ? SPAN_W'(rem_sh - {1'b0, dvs}) : rem_sh[SPAN_W-1:0];
      quotient <= {quotient[PROD_W-2:0], ge};
      step     <= step + 1'b1;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/plti_checker.sv =====
// Port-level checks for the table interpolator, bound to the top level.
`default_nettype none

module plti_checker
  import plti_pkg::*;
(
  input wire logic                  clk,
  input wire logic                  rst,
  input wire logic                  s_axis_tvalid,
  input wire logic                  s_axis_tready,
  input wire logic                  s_axis_tuser,
  input wire logic                  m_axis_tvalid,
  input wire logic                  m_axis_tready,
  input wire logic [OUT_DATA_W-1:0] m_axis_tdata,
  input wire logic                  m_axis_tuser
);

  // Output register is empty right after reset
  a_reset_empty: assert property (@(posedge clk) $past(rst) |-> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("stalled result changed");

  // A miss reports the fixed no-match values
  a_miss_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser |->
      m_axis_tdata[15:0] == 16'hFF83 && m_axis_tdata[31:16] == 16'hFFAA)
    else $error("no-match result carries wrong values");

  // A convert transfer makes the block busy
  a_convert_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && s_axis_tuser |=> !s_axis_tready)
    else $error("ready after convert transfer");

  // A breakpoint write leaves the block ready
  a_write_ready: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && !s_axis_tuser |=> s_axis_tready)
    else $error("not ready after breakpoint write");

endmodule

bind piecewise_linear_table_interp_unit plti_checker u_plti_checker (.*);

`default_nettype wire
